@@ design/twoadic_divide_remainder_defines.svh @@
// assertion macros for the two-adic divide and remainder block
// used by the modules that carry concurrent checks; needs nothing else
`ifndef TWOADIC_DIVIDE_REMAINDER_DEFINES_SVH
`define TWOADIC_DIVIDE_REMAINDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdr check failed");

// next-cycle implication, checked outside reset
`define TDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdr check failed");

`endif

@@ design/tdr_pkg.sv @@
// shared constants and types for the two-adic divide and remainder block
// no dependencies
package tdr_pkg;

    // default data width
    localparam int TDR_WIDTH = 32;

    // status from the iterative core to the stream wrapper
    typedef struct packed {
        logic in_ready;   // core idle, can take a new item
        logic res_valid;  // result held and waiting
    } t_core_stat;

endpackage

@@ design/tdr_core.sv @@
// iterative hensel divide and remainder core: normalise, then one quotient bit per cycle
// depends on tdr_pkg and twoadic_divide_remainder_defines.svh
`include "twoadic_divide_remainder_defines.svh"

module tdr_core #(
    parameter int WIDTH = tdr_pkg::TDR_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_mode,
    input  logic [WIDTH-1:0]      i_num,
    input  logic [WIDTH-1:0]      i_den,
    input  logic                  i_res_ready,
    output tdr_pkg::t_core_stat   o_stat,
    output logic [WIDTH-1:0]      o_result
);
    import tdr_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_STEP,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_cnt;
    logic             r_mode;
    logic [WIDTH-1:0] r_num;   // running dividend
    logic [WIDTH-1:0] r_den;   // divisor, trailing zeros removed
    logic [WIDTH-1:0] r_dsh;   // original divisor shifted to the current bit
    logic [WIDTH-1:0] r_rem;   // original dividend minus the partial product
    logic [WIDTH-1:0] r_q;     // quotient, shifted in from the top
    logic [WIDTH-1:0] sub_diff;

    // subtractor for the quotient step
    assign sub_diff = r_num - r_den;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_mode <= i_mode;
                        r_num  <= i_num;
                        r_den  <= i_den;
                        r_dsh  <= i_den;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        if (i_den == '0) begin
                            // zero divisor gives zero in both modes
                            r_rem   <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_rem   <= i_num;
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    // strip one trailing zero of the divisor per cycle
                    if (r_den[0]) begin
                        r_state <= ST_STEP;
                    end else begin
                        r_num <= r_num >> 1;
                        r_den <= r_den >> 1;
                    end
                end
                ST_STEP: begin
                    // one quotient bit, remainder tracked alongside
                    if (r_num[0]) begin
                        r_num <= sub_diff >> 1;
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {1'b1, r_q[WIDTH-1:1]};
                    end else begin
                        r_num <= r_num >> 1;
                        r_q   <= {1'b0, r_q[WIDTH-1:1]};
                    end
                    r_dsh <= r_dsh << 1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // status and result
    assign o_stat.in_ready  = (r_state == ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_DONE);
    assign o_result         = r_mode ? r_rem : r_q;

    // checks
    `TDR_ASSERT_NEXT(a_zero_div, i_clk, i_rst_n,
        (r_state == ST_IDLE) && i_start && (i_den == '0),
        (r_state == ST_DONE) && (o_result == '0))
    `TDR_ASSERT_NOW(a_norm_nonzero, i_clk, i_rst_n,
        (r_state == ST_NORM), (r_den != '0))
    `TDR_ASSERT_NOW(a_step_odd, i_clk, i_rst_n,
        (r_state == ST_STEP), r_den[0])
    `TDR_ASSERT_NEXT(a_step_runs, i_clk, i_rst_n,
        (r_state == ST_STEP) && (r_cnt != CNT_LAST), (r_state == ST_STEP))
    `TDR_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n,
        (r_state == ST_DONE) && !i_res_ready,
        (r_state == ST_DONE) && $stable(o_result))

endmodule

@@ design/twoadic_divide_remainder.sv @@
// two-adic (hensel) divide and remainder: input and output streams
// around the iterative core; output register decouples the receiver
// depends on tdr_pkg and tdr_core
//
// Usage:
//  - slave stream: i_s_tdata carries dividend (low) and divisor (next),
//    i_s_tuser carries mode (0 quotient, 1 remainder); a transfer happens
//    when i_s_tvalid and o_s_tready are both high
//  - master stream: o_m_tdata carries the result, transferred when
//    o_m_tvalid and i_m_tready are both high
//  - o_s_tready is high only while the core is idle; between input
//    transfers the core takes the transfer, strips the divisor's trailing
//    zeros one at a time, sees the divisor odd, forms one quotient bit per
//    step and hands the result over, which waits while the output register
//    is full; a zero divisor goes straight to handing the result over
//  - o_m_tvalid rises once the output register takes the core's result,
//    and the next item can be taken while it waits
//  - a stalled receiver holds o_m_tdata; once the output register and
//    the core both hold results, o_s_tready stays low
//  - synchronous active-low reset empties the output register and idles the core
module twoadic_divide_remainder #(
    parameter int WIDTH = tdr_pkg::TDR_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // fields from bit 0: dividend, divisor, zero padding
    input  logic [((2*WIDTH+7)/8)*8-1:0]        i_s_tdata,
    // fields from bit 0: mode
    input  logic [0:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // fields from bit 0: result, zero padding
    output logic [((WIDTH+7)/8)*8-1:0]          o_m_tdata
);
    import tdr_pkg::*;

    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    t_core_stat       core_stat;
    logic [WIDTH-1:0] core_result;
    logic             res_ready;
    logic             r_m_tvalid;
    logic [WIDTH-1:0] r_m_tdata;

    // output register takes a result when empty or being drained
    assign res_ready  = !r_m_tvalid || i_m_tready;
    assign o_s_tready = core_stat.in_ready;

    tdr_core #(
        .WIDTH (WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_tvalid && core_stat.in_ready),
        .i_mode      (i_s_tuser[0]),
        .i_num       (i_s_tdata[WIDTH-1:0]),
        .i_den       (i_s_tdata[2*WIDTH-1:WIDTH]),
        .i_res_ready (res_ready),
        .o_stat      (core_stat),
        .o_result    (core_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_ready) begin
            r_m_tvalid <= core_stat.res_valid;
            if (core_stat.res_valid) begin
                r_m_tdata <= core_result;
            end
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = OUT_W'(r_m_tdata);

endmodule
